FILE: design/lru_page_replacement_defines.svh
// Assertion helpers for the LRU page replacement block.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define LRP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lru_page_replacement: assertion failed");
`define LRP_ASSERT_IMP(lbl, ante, cons) `LRP_ASSERT(lbl, (ante) |-> (cons))
`else
`define LRP_ASSERT(lbl, prop)
`define LRP_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

FILE: design/lrp_pkg.sv
package lrp_pkg;

    localparam int FRAMES     = 8;
    localparam int PAGE_BITS  = 8;
    localparam int COUNT_BITS = 16;
    localparam int CFG_BITS   = 4;
    localparam int SLOT_BITS  = 3;
    localparam int IDX_BITS   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int AGE_BITS   = IDX_BITS;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(8);

    typedef logic [IDX_BITS-1:0]  t_idx;
    typedef logic [AGE_BITS-1:0]  t_age;
    typedef logic [PAGE_BITS-1:0] t_page;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    // Search results rippling from cell 0 upward.
    typedef struct packed {
        logic  hit_found;
        t_idx  hit_idx;
        t_age  hit_age;
        logic  empty_found;
        t_idx  empty_idx;
        t_age  max_age;
        t_idx  max_idx;
        t_page max_page;
    } t_chain;

    // Update broadcast to every cell.
    typedef struct packed {
        logic  upd;
        logic  clear;
        t_idx  slot;
        logic  age_all;
        t_age  old_age;
        logic  wr_page;
        t_page page;
    } t_cmd;

endpackage

FILE: design/lrp_cell.sv
module lrp_cell import lrp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_idx   i_idx,
    input  logic   i_active,
    input  t_page  i_key,
    input  t_chain i_chain,
    output t_chain o_chain,
    input  t_cmd   i_cmd,
    output logic   o_valid
);

    logic  r_valid, n_valid;
    t_age  r_age, n_age;
    t_page r_page, n_page;
    logic  w_hit, w_empty, w_max;

    // Lowest active index wins for hit and empty; strict compare keeps lowest on ties.
    // Cell 0 always seeds the oldest-frame search, even at age 0.
    always_comb begin
        w_hit   = i_active && r_valid && (r_page == i_key) && !i_chain.hit_found;
        w_empty = i_active && !r_valid && !i_chain.empty_found;
        w_max   = i_active && ((r_age > i_chain.max_age) || (i_idx == '0));

        o_chain             = i_chain;
        o_chain.hit_found   = i_chain.hit_found | w_hit;
        o_chain.empty_found = i_chain.empty_found | w_empty;
        if (w_hit) begin
            o_chain.hit_idx = i_idx;
            o_chain.hit_age = r_age;
        end
        if (w_empty) begin
            o_chain.empty_idx = i_idx;
        end
        if (w_max) begin
            o_chain.max_age  = r_age;
            o_chain.max_idx  = i_idx;
            o_chain.max_page = r_page;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_age   = r_age;
        n_page  = r_page;
        if (i_cmd.upd) begin
            if (i_idx == i_cmd.slot) begin
                n_valid = 1'b1;
                n_age   = '0;
                if (i_cmd.wr_page) begin
                    n_page = i_cmd.page;
                end
            end else if (r_valid && (i_cmd.age_all || (r_age < i_cmd.old_age))
                         && (r_age != '1)) begin
                n_age = r_age + t_age'(1);
            end
            if (i_cmd.clear) begin
                n_valid = 1'b0;
                n_age   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
        end
        r_page <= n_page;
    end

    assign o_valid = r_valid;

endmodule

FILE: design/lru_page_replacement.sv
// LRU page replacement, one row of frame cells with a rippled search.
// A transaction passes through the LOOKUP and UPDATE states to the registered result.
// A new transaction is taken only in IDLE, once the lookup/update sequencer is done with the last one;
// the update waits while the result register is still held by the consumer.
// Reset (synchronous, active low): all frames empty, ages and fault count zero,
// frame count 8, no result pending.
`include "lru_page_replacement_defines.svh"

module lru_page_replacement import lrp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration: frame count
    input  logic                  i_cfg_we,
    input  logic [CFG_BITS-1:0]   i_cfg_wdata,
    // reference input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic                  i_last_ref,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_fault,
    output logic [SLOT_BITS-1:0]  o_slot,
    output logic                  o_evicted_valid,
    output logic [PAGE_BITS-1:0]  o_evicted_page,
    output logic [COUNT_BITS-1:0] o_fault_total
);

    t_state r_state, n_state;

    logic [CFG_BITS-1:0] r_frame_count;

    // captured transaction
    t_page r_page;
    logic  r_last;

    // decision latched at the end of lookup
    logic  r_hit;
    logic  r_fill;
    t_idx  r_slot;
    t_age  r_old_age;
    t_page r_ev_page;

    logic [COUNT_BITS-1:0] r_fault_cnt;
    logic [COUNT_BITS-1:0] w_cnt_next;

    // result register
    logic                  r_out_valid;
    logic                  r_out_fault;
    t_idx                  r_out_slot;
    logic                  r_out_ev_valid;
    t_page                 r_out_ev_page;
    logic [COUNT_BITS-1:0] r_out_total;

    logic w_accept;
    logic w_lookup;
    logic w_upd;

    t_chain              w_chain [FRAMES+1];
    logic [FRAMES-1:0]   w_valid_vec;
    t_cmd                w_cmd;

    //------------------------------------------------------------------
    // Sequencer: IDLE takes a transaction, LOOKUP latches the search,
    // UPDATE writes the cells once the result register can take the result.
    //------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = ST_UPDATE;
            ST_UPDATE: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_lookup   = 1'b0;
        w_upd      = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_LOOKUP: w_lookup = 1'b1;
            ST_UPDATE: w_upd = !r_out_valid || i_out_ready;
            default:   o_in_ready = 1'b0;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Frame count register; out-of-range values are handled by the active masks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_frame_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= i_page;
            r_last <= i_last_ref;
        end
    end

    //------------------------------------------------------------------
    // Cell row. Search ripples from cell 0, so the first match, the first
    // empty frame and the oldest frame all resolve to the lowest index.
    // Frame 0 is always active; frame g is active when frame_count > g.
    //------------------------------------------------------------------
    assign w_chain[0] = '0;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        lrp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (t_idx'(g)),
            .i_active((g == 0) || (r_frame_count > CFG_BITS'(g))),
            .i_key   (r_page),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .i_cmd   (w_cmd),
            .o_valid (w_valid_vec[g])
        );
    end

    // Hit beats fill beats eviction.
    always_ff @(posedge i_clk) begin
        if (w_lookup) begin
            r_hit     <= w_chain[FRAMES].hit_found;
            r_fill    <= !w_chain[FRAMES].hit_found && w_chain[FRAMES].empty_found;
            r_ev_page <= w_chain[FRAMES].max_page;
            if (w_chain[FRAMES].hit_found) begin
                r_slot    <= w_chain[FRAMES].hit_idx;
                r_old_age <= w_chain[FRAMES].hit_age;
            end else if (w_chain[FRAMES].empty_found) begin
                r_slot    <= w_chain[FRAMES].empty_idx;
                r_old_age <= '0;
            end else begin
                r_slot    <= w_chain[FRAMES].max_idx;
                r_old_age <= w_chain[FRAMES].max_age;
            end
        end
    end

    // On a fill every resident frame ages; otherwise only those younger than the slot.
    always_comb begin
        w_cmd.upd     = w_upd;
        w_cmd.clear   = r_last;
        w_cmd.slot    = r_slot;
        w_cmd.age_all = r_fill;
        w_cmd.old_age = r_old_age;
        w_cmd.wr_page = !r_hit;
        w_cmd.page    = r_page;
    end

    // Saturating fault count; the reported total includes this fault.
    assign w_cnt_next = (!r_hit && (r_fault_cnt != '1))
                        ? r_fault_cnt + COUNT_BITS'(1) : r_fault_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_cnt <= '0;
        end else if (w_upd) begin
            r_fault_cnt <= r_last ? '0 : w_cnt_next;
        end
    end

    // Result register frees the input side while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_upd) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_out_fault    <= !r_hit;
            r_out_slot     <= r_slot;
            r_out_ev_valid <= !r_hit && !r_fill;
            r_out_ev_page  <= (!r_hit && !r_fill) ? r_ev_page : '0;
            r_out_total    <= w_cnt_next;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fault         = r_out_fault;
    assign o_slot          = SLOT_BITS'(r_out_slot);
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_total   = r_out_total;

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
    `LRP_ASSERT(a_last_clears, (w_upd && r_last) |=> (w_valid_vec == '0))
    `LRP_ASSERT(a_one_fill, w_upd |=> $countones(w_valid_vec) <= $countones($past(w_valid_vec)) + 1)
    `LRP_ASSERT_IMP(a_evict_is_fault, r_out_valid && r_out_ev_valid, r_out_fault)
    `LRP_ASSERT_IMP(a_fault_counted, r_out_valid && r_out_fault, r_out_total != '0)

endmodule
